/* rtl/ope_pkg.sv */
// package for the operator precedence evaluator
// holds token and operator codes, status codes, state enum and precedence table
`timescale 1ns / 1ps
package ope_pkg;

   localparam int unsigned KIND_W = 3;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned STAT_W = 3;

   typedef enum logic [2:0] {
      KIND_NUMBER = 3'd0,
      KIND_PLUS   = 3'd1,
      KIND_MINUS  = 3'd2,
      KIND_TIMES  = 3'd3,
      KIND_DIVIDE = 3'd4,
      KIND_OPEN   = 3'd5,
      KIND_CLOSE  = 3'd6,
      KIND_END    = 3'd7
   } kind_type;

   // operator codes as kept on the operator stack
   typedef enum logic [2:0] {
      OPC_ADD   = 3'd0,
      OPC_SUB   = 3'd1,
      OPC_MUL   = 3'd2,
      OPC_DIV   = 3'd3,
      OPC_OPEN  = 3'd4,
      OPC_CLOSE = 3'd5,
      OPC_END   = 3'd6
   } opc_type;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_DIV0    = 3'd1,
      STAT_PAREN   = 3'd2,
      STAT_OVERFLW = 3'd3,
      STAT_UNDERFL = 3'd4
   } stat_type;

   typedef enum logic [1:0] {
      PREC_EQUAL  = 2'd0,
      PREC_SHIFT  = 2'd1,
      PREC_REDUCE = 2'd2,
      PREC_ERROR  = 2'd3
   } prec_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOK,
      ST_READ_B,
      ST_READ_A,
      ST_ALU_START,
      ST_ALU_WAIT,
      ST_PUSH_RES,
      ST_END_CHECK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic start;
      logic [1:0] op;  // add, sub, mul, div
   } alu_cmd_type;

   typedef struct packed {
      logic done;
      logic div0;
   } alu_stat_type;

   function automatic prec_type prec_lookup(input logic [2:0] top, input logic [2:0] tok);
      prec_type p;
      p = PREC_ERROR;
      unique case (top)
         OPC_ADD, OPC_SUB:
            p = (tok == OPC_MUL || tok == OPC_DIV || tok == OPC_OPEN) ? PREC_SHIFT : PREC_REDUCE;
         OPC_MUL, OPC_DIV:
            p = (tok == OPC_OPEN) ? PREC_SHIFT : PREC_REDUCE;
         OPC_OPEN:
            p = (tok == OPC_CLOSE) ? PREC_EQUAL :
                (tok == OPC_END) ? PREC_ERROR : PREC_SHIFT;
         OPC_CLOSE:
            p = (tok == OPC_OPEN) ? PREC_ERROR : PREC_REDUCE;
         OPC_END:
            p = (tok == OPC_CLOSE) ? PREC_ERROR :
                (tok == OPC_END) ? PREC_EQUAL : PREC_SHIFT;
         default:
            p = PREC_ERROR;
      endcase
      return p;
   endfunction

endpackage

/* rtl/ope_if.sv */
// valid/ready channel interface
// depends on nothing
`timescale 1ns / 1ps
interface ope_if #(parameter int unsigned PayloadWidth = 35);
   logic                    valid;
   logic                    ready;
   logic [PayloadWidth-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/operator_precedence_evaluator_top.sv */
// operator precedence evaluator: sequencer, two stacks and the shared arithmetic unit
// depends on ope_pkg, ope_if and ope_alu
//
//   channel | dir | payload
//   req     | in  | {kind[2:0], number[31:0]}, number in bits 31:0
//   rsp     | out | {status[2:0], value[31:0]}, value in bits 31:0
//
// a number token is stored from idle; an operator passes look and end check plus each reduction.
// a reduction reads both operands, then runs the shared unit, whose multiply and divide are
// loops, and pushes the result; req is held low.
// the result waits in an output register; req stays low until it is taken.
// reset leaves each stack with one entry: end mark and zero; no clearing pass.
`timescale 1ns / 1ps
module operator_precedence_evaluator_top #(
   parameter int unsigned OP_DEPTH  = 16,
   parameter int unsigned NUM_DEPTH = 16,
   parameter int unsigned FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   ope_if.sink   req,
   ope_if.source rsp
);
   localparam int unsigned OW = $clog2(OP_DEPTH + 1);
   localparam int unsigned NW = $clog2(NUM_DEPTH + 1);
   localparam int unsigned OA = $clog2(OP_DEPTH);
   localparam int unsigned NA = $clog2(NUM_DEPTH);

   logic [2:0]  op_mem  [OP_DEPTH];
   logic [31:0] num_mem [NUM_DEPTH];

   ope_pkg::state_type st_ff, st_in;
   logic [OW-1:0] op_cnt_ff, op_cnt_in;
   logic [NW-1:0] num_cnt_ff, num_cnt_in;
   logic [2:0]    err_ff, err_in;
   logic [2:0]    tok_ff, tok_in;
   logic          is_end_ff, is_end_in;
   logic [2:0]    top_ff;
   logic [31:0]   rd_ff, a_ff, a_in, b_ff, b_in;
   logic          rv_ff, rv_in;
   logic [31:0]   rval_ff, rval_in;
   logic [2:0]    rstat_ff, rstat_in;

   logic          op_we, num_we;
   logic [OA-1:0] op_wa, op_ra;
   logic [2:0]    op_wd;
   logic [NA-1:0] num_wa, num_ra;
   logic [31:0]   num_wd;
   ope_pkg::alu_cmd_type alu_cmd;
   ope_pkg::alu_stat_type alu_stat;
   logic signed [31:0] alu_res;
   ope_pkg::prec_type prec;
   logic [2:0] top_op;

   ope_alu #(.FracBits(FRAC_BITS)) u_alu (
      .clock(clock), .reset(reset), .cmd(alu_cmd),
      .a(a_ff), .b(b_ff), .result(alu_res), .stat(alu_stat)
   );

   // operator entry zero is the end mark, so its value is never taken from memory
   assign top_op = (op_cnt_ff <= OW'(1)) ? ope_pkg::OPC_END : top_ff;
   assign prec = ope_pkg::prec_lookup(top_op, tok_ff);
   assign op_ra = OA'(op_cnt_ff - 1'b1);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ope_pkg::ST_IDLE:
            if (req.valid && req.ready) begin
               if (req.payload[34:32] == ope_pkg::KIND_NUMBER) st_in = ope_pkg::ST_IDLE;
               else if (err_ff != ope_pkg::STAT_OK) begin
                  st_in = (req.payload[34:32] == ope_pkg::KIND_END) ?
                          ope_pkg::ST_END_CHECK : ope_pkg::ST_IDLE;
               end else st_in = ope_pkg::ST_LOOK;
            end
         ope_pkg::ST_LOOK: begin
            if (tok_ff == ope_pkg::OPC_END && top_op == ope_pkg::OPC_END)
               st_in = ope_pkg::ST_END_CHECK;
            else unique case (prec)
               ope_pkg::PREC_REDUCE:
                  st_in = (num_cnt_ff < NW'(2)) ? ope_pkg::ST_END_CHECK : ope_pkg::ST_READ_B;
               default: st_in = ope_pkg::ST_END_CHECK;
            endcase
         end
         ope_pkg::ST_READ_B:    st_in = ope_pkg::ST_READ_A;
         ope_pkg::ST_READ_A:    st_in = ope_pkg::ST_ALU_START;
         ope_pkg::ST_ALU_START: st_in = ope_pkg::ST_ALU_WAIT;
         ope_pkg::ST_ALU_WAIT:
            if (alu_stat.done) st_in = ope_pkg::ST_PUSH_RES;
         ope_pkg::ST_PUSH_RES:
            st_in = alu_stat.div0 ? ope_pkg::ST_END_CHECK : ope_pkg::ST_LOOK;
         ope_pkg::ST_END_CHECK:
            st_in = is_end_ff ? ope_pkg::ST_RESULT : ope_pkg::ST_IDLE;
         ope_pkg::ST_RESULT:
            if (!rv_ff) st_in = ope_pkg::ST_IDLE;
         default: st_in = ope_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      op_cnt_in = op_cnt_ff; num_cnt_in = num_cnt_ff; err_in = err_ff;
      tok_in = tok_ff; is_end_in = is_end_ff; a_in = a_ff; b_in = b_ff;
      rv_in = rv_ff; rval_in = rval_ff; rstat_in = rstat_ff;
      op_we = 1'b0; op_wa = OA'(op_cnt_ff); op_wd = tok_ff;
      num_we = 1'b0; num_wa = NA'(num_cnt_ff); num_wd = req.payload[31:0];
      num_ra = NA'(num_cnt_ff - 1'b1);
      alu_cmd.start = 1'b0; alu_cmd.op = top_op[1:0];
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      unique case (st_ff)
         ope_pkg::ST_IDLE:
            if (req.valid && req.ready) begin
               tok_in = req.payload[34:32] - 3'd1;
               is_end_in = req.payload[34:32] == ope_pkg::KIND_END;
               if (req.payload[34:32] == ope_pkg::KIND_NUMBER && err_ff == ope_pkg::STAT_OK) begin
                  if (num_cnt_ff >= NW'(NUM_DEPTH)) err_in = ope_pkg::STAT_OVERFLW;
                  else begin
                     num_we = 1'b1;
                     num_cnt_in = num_cnt_ff + 1'b1;
                  end
               end
            end
         ope_pkg::ST_LOOK:
            if (!(tok_ff == ope_pkg::OPC_END && top_op == ope_pkg::OPC_END)) begin
               unique case (prec)
                  ope_pkg::PREC_SHIFT:
                     if (op_cnt_ff >= OW'(OP_DEPTH)) err_in = ope_pkg::STAT_OVERFLW;
                     else begin
                        op_we = 1'b1;
                        op_cnt_in = op_cnt_ff + 1'b1;
                     end
                  ope_pkg::PREC_EQUAL: op_cnt_in = op_cnt_ff - 1'b1;
                  ope_pkg::PREC_ERROR: err_in = ope_pkg::STAT_PAREN;
                  default: begin
                     if (num_cnt_ff < NW'(2)) err_in = ope_pkg::STAT_UNDERFL;
                  end
               endcase
            end
         ope_pkg::ST_READ_B: begin
            b_in = rd_ff;
            num_ra = NA'(num_cnt_ff - 2'd2);
         end
         ope_pkg::ST_READ_A: begin
            a_in = rd_ff;
         end
         ope_pkg::ST_ALU_START: begin
            alu_cmd.start = 1'b1;
            op_cnt_in = op_cnt_ff - 1'b1;
            num_cnt_in = num_cnt_ff - 2'd2;
         end
         ope_pkg::ST_ALU_WAIT: ;
         ope_pkg::ST_PUSH_RES:
            if (alu_stat.div0) err_in = ope_pkg::STAT_DIV0;
            else begin
               num_we = 1'b1;
               num_wd = alu_res;
               num_cnt_in = num_cnt_ff + 1'b1;
            end
         ope_pkg::ST_END_CHECK:
            if (is_end_ff) begin
               if (err_ff == ope_pkg::STAT_OK && num_cnt_ff == '0) begin
                  rval_in = '0; rstat_in = ope_pkg::STAT_UNDERFL;
               end else if (err_ff != ope_pkg::STAT_OK) begin
                  rval_in = '0; rstat_in = err_ff;
               end else begin
                  rval_in = rd_ff;
                  rstat_in = ope_pkg::STAT_OK;
               end
               rv_in = 1'b1;
               op_cnt_in = OW'(1); num_cnt_in = NW'(1); err_in = ope_pkg::STAT_OK;
               // reseed the operand stack with zero
               num_we = 1'b1; num_wa = '0; num_wd = '0;
            end
         default: ;
      endcase
   end

   // stack memories; the operand read port serves the top in the end check as well
   always_ff @(posedge clock) begin
      if (op_we) op_mem[op_wa] <= op_wd;
      if (reset) num_mem[0] <= '0;
      else if (num_we) num_mem[num_wa] <= num_wd;
      top_ff <= op_mem[op_ra];
      rd_ff <= num_mem[num_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ope_pkg::ST_IDLE;
         op_cnt_ff <= OW'(1);
         num_cnt_ff <= NW'(1);
         err_ff <= ope_pkg::STAT_OK;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         op_cnt_ff <= op_cnt_in;
         num_cnt_ff <= num_cnt_in;
         err_ff <= err_in;
         rv_ff <= rv_in;
      end
      tok_ff <= tok_in; is_end_ff <= is_end_in;
      a_ff <= a_in; b_ff <= b_in;
      rval_ff <= rval_in; rstat_ff <= rstat_in;
   end

   assign req.ready = (st_ff == ope_pkg::ST_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.payload = {rstat_ff, rval_ff};
endmodule

/* rtl/ope_alu.sv */
// shared fixed point unit: add, sub, rounded multiply and bit-serial rounded divide
// depends on ope_pkg; multiply is split into 16x16 partial products, one per cycle
`timescale 1ns / 1ps
module ope_alu #(
   parameter int unsigned FracBits = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ope_pkg::alu_cmd_type cmd,
   input  logic signed [31:0]   a,
   input  logic signed [31:0]   b,
   output logic signed [31:0]   result,
   output ope_pkg::alu_stat_type stat
);
   localparam int unsigned QW = 32 + FracBits; // dividend width
   localparam int unsigned CW = $clog2(QW + 1);
   localparam logic [63:0] MaxPos = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] MaxNeg = 64'h0000_0000_8000_0000;

   logic [1:0]    op_ff, op_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          div0_ff, div0_in;
   logic          neg_ff, neg_in;
   logic [32:0]   ua_ff, ua_in;
   logic [32:0]   ub_ff, ub_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [63:0]   acc_ff, acc_in;     // product accumulator or quotient
   logic [33:0]   rem_ff, rem_in;     // division remainder
   logic [QW-1:0] dvd_ff, dvd_in;     // dividend shift register
   logic signed [31:0] res_ff, res_in;

   logic [32:0] amag, bmag;
   logic [15:0] pa, pb;
   logic [31:0] pp;
   logic [63:0] pp_sh;
   logic [33:0] rem_sh;
   logic [63:0] mag_fin, rnd_mul, rnd_div;
   logic signed [33:0] sum;

   assign amag = a[31] ? 33'(-{a[31], a}) : {1'b0, a};
   assign bmag = b[31] ? 33'(-{b[31], b}) : {1'b0, b};
   // cnt selects halves: cnt[1] for a, cnt[0] for b
   assign pa = cnt_ff[1] ? ua_ff[31:16] : ua_ff[15:0];
   assign pb = cnt_ff[0] ? ub_ff[31:16] : ub_ff[15:0];
   assign pp = pa * pb;
   assign pp_sh = 64'(pp) << (16 * (32'(cnt_ff[1]) + 32'(cnt_ff[0])));
   assign rem_sh = {rem_ff[32:0], dvd_ff[QW-1]};
   assign sum = (op_ff == 2'd0) ? 34'(a) + 34'(b) : 34'(a) - 34'(b);

   // rounding: products add half lsb, quotients compare twice remainder with divisor
   assign rnd_mul = (acc_ff + ((64'd1 << FracBits) >> 1)) >> FracBits;
   assign rnd_div = acc_ff + 64'({rem_ff[32:0], 1'b0} >= {1'b0, ub_ff});
   assign mag_fin = (op_ff == 2'd2) ? rnd_mul : rnd_div;

   always_comb begin
      op_in = op_ff; busy_in = busy_ff; done_in = 1'b0; div0_in = div0_ff;
      neg_in = neg_ff; ua_in = ua_ff; ub_in = ub_ff; cnt_in = cnt_ff;
      acc_in = acc_ff; rem_in = rem_ff; dvd_in = dvd_ff; res_in = res_ff;
      if (cmd.start) begin
         op_in = cmd.op; div0_in = 1'b0;
         neg_in = a[31] != b[31];
         ua_in = amag; ub_in = bmag;
         acc_in = '0; rem_in = '0; cnt_in = '0;
         dvd_in = QW'(amag) << FracBits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         unique case (op_ff)
            2'd0, 2'd1: begin
               if (sum > 34'sh0_7FFF_FFFF) res_in = 32'sh7FFF_FFFF;
               else if (sum < -34'sh0_8000_0000) res_in = 32'sh8000_0000;
               else res_in = sum[31:0];
               busy_in = 1'b0; done_in = 1'b1;
            end
            2'd2: begin
               if (cnt_ff == CW'(4)) begin
                  busy_in = 1'b0; done_in = 1'b1;
               end else begin
                  acc_in = acc_ff + pp_sh;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            default: begin
               if (ub_ff == '0) begin
                  div0_in = 1'b1; res_in = '0;
                  busy_in = 1'b0; done_in = 1'b1;
               end else if (cnt_ff == CW'(QW)) begin
                  busy_in = 1'b0; done_in = 1'b1;
               end else begin
                  if (rem_sh >= {1'b0, ub_ff}) begin
                     rem_in = rem_sh - {1'b0, ub_ff};
                     acc_in = {acc_ff[62:0], 1'b1};
                  end else begin
                     rem_in = rem_sh;
                     acc_in = {acc_ff[62:0], 1'b0};
                  end
                  dvd_in = dvd_ff << 1;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         endcase
         // saturate magnitude result once multiply or divide finishes
         if (done_in && !div0_in && op_ff[1]) begin
            if (!neg_ff) res_in = (mag_fin > MaxPos) ? 32'sh7FFF_FFFF : mag_fin[31:0];
            else res_in = (mag_fin >= MaxNeg) ? 32'sh8000_0000 : 32'(-mag_fin[31:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff <= op_in; div0_ff <= div0_in; neg_ff <= neg_in;
      ua_ff <= ua_in; ub_ff <= ub_in; cnt_ff <= cnt_in;
      acc_ff <= acc_in; rem_ff <= rem_in; dvd_ff <= dvd_in; res_ff <= res_in;
   end

   assign result = res_ff;
   assign stat.done = done_ff;
   assign stat.div0 = div0_ff;
endmodule

/* dv/tb_operator_precedence_evaluator_top.sv */
// testbench for the operator precedence evaluator: directed and random expressions
// depends on ope_pkg, ope_if and operator_precedence_evaluator_top
`timescale 1ns / 1ps
module tb_operator_precedence_evaluator_top;

   localparam int OpDepth  = 16;
   localparam int NumDepth = 16;
   localparam int FracBits = 16;
   localparam int WatchdogLimit = 20000;

   typedef struct packed {
      ope_pkg::stat_type status;
      logic [31:0]       value;
   } eval_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ope_if #(.PayloadWidth(35)) req ();
   ope_if #(.PayloadWidth(35)) rsp ();

   operator_precedence_evaluator_top #(
      .OP_DEPTH(OpDepth), .NUM_DEPTH(NumDepth), .FRAC_BITS(FracBits)
   ) u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   ope_pkg::opc_type   pred_ops[OpDepth];
   int                 pred_op_cnt;
   logic signed [31:0] pred_nums[NumDepth];
   int                 pred_num_cnt;
   ope_pkg::stat_type  pred_err;
   eval_result_type    expected_results[$];
   int                 error_count = 0;
   int                 idle_cycles = 0;
   bit                 stall_long = 1'b0;

   function automatic logic signed [31:0] sat32(logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [63:0] signed_mag(logic [63:0] m, bit neg);
      if (m > (64'd1 << 62)) m = 64'd1 << 62;
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic int prec_of(ope_pkg::opc_type top, ope_pkg::opc_type tok);
      case (top)
         ope_pkg::OPC_ADD, ope_pkg::OPC_SUB:
            return (tok == ope_pkg::OPC_MUL || tok == ope_pkg::OPC_DIV ||
                    tok == ope_pkg::OPC_OPEN) ? 1 : 2;
         ope_pkg::OPC_MUL, ope_pkg::OPC_DIV: return (tok == ope_pkg::OPC_OPEN) ? 1 : 2;
         ope_pkg::OPC_OPEN:
            return (tok == ope_pkg::OPC_CLOSE) ? 0 : (tok == ope_pkg::OPC_END) ? -1 : 1;
         ope_pkg::OPC_CLOSE: return (tok == ope_pkg::OPC_OPEN) ? -1 : 2;
         default: return (tok == ope_pkg::OPC_CLOSE) ? -1 : (tok == ope_pkg::OPC_END) ? 0 : 1;
      endcase
   endfunction

   function automatic logic signed [31:0] arith(logic signed [31:0] a, ope_pkg::opc_type op,
                                                logic signed [31:0] b);
      bit neg;
      logic [63:0] ua, ub;
      logic signed [63:0] wa, wb;
      wa = a;
      wb = b;
      neg = (a < 0) != (b < 0);
      ua = (wa < 0) ? -wa : wa;
      ub = (wb < 0) ? -wb : wb;
      case (op)
         ope_pkg::OPC_ADD: return sat32(wa + wb);
         ope_pkg::OPC_SUB: return sat32(wa - wb);
         ope_pkg::OPC_MUL:
            return sat32(signed_mag((ua * ub + ((64'd1 << FracBits) >> 1)) >> FracBits, neg));
         default: begin
            if (ub == 0) begin
               pred_err = ope_pkg::STAT_DIV0;
               return 0;
            end
            return sat32(signed_mag(((ua << FracBits) + ub / 2) / ub, neg));
         end
      endcase
   endfunction

   function automatic void clear_eval();
      pred_ops[0] = ope_pkg::OPC_END;
      pred_op_cnt = 1;
      pred_nums[0] = 0;
      pred_num_cnt = 1;
      pred_err = ope_pkg::STAT_OK;
   endfunction

   function automatic void feed_operator(ope_pkg::opc_type t);
      ope_pkg::opc_type top;
      int p;
      logic signed [31:0] a, b, r;
      forever begin
         top = (pred_op_cnt == 0) ? ope_pkg::OPC_END : pred_ops[pred_op_cnt-1];
         if (t == ope_pkg::OPC_END && top == ope_pkg::OPC_END) return;
         p = prec_of(top, t);
         if (p == 1) begin
            if (pred_op_cnt >= OpDepth) begin
               pred_err = ope_pkg::STAT_OVERFLW;
               return;
            end
            pred_ops[pred_op_cnt++] = t;
            return;
         end else if (p == 0) begin
            if (pred_op_cnt > 0) pred_op_cnt--;
            return;
         end else if (p < 0) begin
            pred_err = ope_pkg::STAT_PAREN;
            return;
         end else begin
            if (pred_num_cnt < 2) begin
               pred_err = ope_pkg::STAT_UNDERFL;
               return;
            end
            b = pred_nums[pred_num_cnt-1];
            a = pred_nums[pred_num_cnt-2];
            pred_num_cnt -= 2;
            pred_op_cnt--;
            r = arith(a, top, b);
            if (pred_err != ope_pkg::STAT_OK) return;
            pred_nums[pred_num_cnt++] = r;
         end
      end
   endfunction

   function automatic void predict_token(ope_pkg::kind_type k, logic [31:0] num);
      eval_result_type res;
      if (k == ope_pkg::KIND_NUMBER) begin
         if (pred_err == ope_pkg::STAT_OK) begin
            if (pred_num_cnt >= NumDepth) pred_err = ope_pkg::STAT_OVERFLW;
            else pred_nums[pred_num_cnt++] = num;
         end
         return;
      end
      if (pred_err == ope_pkg::STAT_OK) feed_operator(ope_pkg::opc_type'(k - 3'd1));
      if (k != ope_pkg::KIND_END) return;
      if (pred_err == ope_pkg::STAT_OK && pred_num_cnt == 0) pred_err = ope_pkg::STAT_UNDERFL;
      res.status = pred_err;
      res.value = (pred_err == ope_pkg::STAT_OK) ? pred_nums[pred_num_cnt-1] : 32'd0;
      expected_results.push_back(res);
      clear_eval();
   endfunction

   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // sends one token; inputs change on the falling edge
   task automatic send_token(ope_pkg::kind_type k, logic [31:0] num = 32'd0);
      int gap;
      gap = rand_gap();
      repeat (gap) begin
         @(negedge clock);
         req.valid <= 1'b0;
      end
      @(negedge clock);
      req.valid <= 1'b1;
      req.payload <= {k, num};
      do @(posedge clock); while (!req.ready);
      predict_token(k, num);
      @(negedge clock);
      req.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_number();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'd0;
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   task automatic test_directed();
      // leading minus and basic precedence
      send_token(ope_pkg::KIND_MINUS); send_token(ope_pkg::KIND_NUMBER, 32'h0003_0000);
      send_token(ope_pkg::KIND_PLUS); send_token(ope_pkg::KIND_NUMBER, 32'h0002_0000);
      send_token(ope_pkg::KIND_TIMES); send_token(ope_pkg::KIND_NUMBER, 32'hFFFF_8000);
      send_token(ope_pkg::KIND_END);
      // parentheses, divide, saturation
      send_token(ope_pkg::KIND_OPEN); send_token(ope_pkg::KIND_NUMBER, 32'h7FFF_FFFF);
      send_token(ope_pkg::KIND_PLUS); send_token(ope_pkg::KIND_NUMBER, 32'h7FFF_FFFF);
      send_token(ope_pkg::KIND_CLOSE); send_token(ope_pkg::KIND_DIVIDE);
      send_token(ope_pkg::KIND_NUMBER, 32'h8000_0000); send_token(ope_pkg::KIND_END);
      // divide by zero, then tokens after the error
      send_token(ope_pkg::KIND_NUMBER, 32'h0001_0000); send_token(ope_pkg::KIND_DIVIDE);
      send_token(ope_pkg::KIND_NUMBER, 32'd0); send_token(ope_pkg::KIND_PLUS);
      send_token(ope_pkg::KIND_END);
      // stray close paren, open left pending, underflow
      send_token(ope_pkg::KIND_CLOSE); send_token(ope_pkg::KIND_END);
      send_token(ope_pkg::KIND_OPEN); send_token(ope_pkg::KIND_END);
      send_token(ope_pkg::KIND_PLUS); send_token(ope_pkg::KIND_TIMES);
      send_token(ope_pkg::KIND_END);
   endtask

   task automatic test_overflow();
      // operand stack overflow, then operator stack overflow
      repeat (NumDepth) send_token(ope_pkg::KIND_NUMBER, rand_number());
      send_token(ope_pkg::KIND_END);
      repeat (OpDepth) send_token(ope_pkg::KIND_OPEN);
      send_token(ope_pkg::KIND_END);
   endtask

   task automatic test_random(int n_tokens);
      int sent, depth, mode;
      sent = 0;
      while (sent < n_tokens) begin
         mode = $urandom_range(0, 9);
         depth = 0;
         if (mode == 0) begin
            // noise: any token at random
            repeat ($urandom_range(1, 8)) begin
               send_token(ope_pkg::kind_type'($urandom_range(0, 7)), $urandom());
               sent++;
            end
         end else begin
            // expression with random content, well formed but for unclosed parens in mode 1
            send_token(ope_pkg::KIND_NUMBER, rand_number());
            sent++;
            repeat ($urandom_range(0, 6)) begin
               send_token(ope_pkg::kind_type'($urandom_range(ope_pkg::KIND_PLUS,
                                                             ope_pkg::KIND_DIVIDE)));
               if (depth < 3 && $urandom_range(0, 3) == 0) begin
                  send_token(ope_pkg::KIND_OPEN);
                  depth++;
               end
               send_token(ope_pkg::KIND_NUMBER, rand_number());
               sent += 2;
               if (depth > 0 && $urandom_range(0, 2) == 0) begin
                  send_token(ope_pkg::KIND_CLOSE);
                  depth--;
               end
            end
            while (depth > 0 && mode != 1) begin
               send_token(ope_pkg::KIND_CLOSE);
               depth--;
            end
         end
         send_token(ope_pkg::KIND_END);
         sent++;
      end
   endtask

   // receiver stall and result check
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if ($urandom_range(0, 199) == 0) stall_long <= ~stall_long;
      else rsp.ready <= stall_long ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      eval_result_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = rsp.payload;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected transaction value=%h status=%0d", $time, got.value,
                     got.status);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.value !== want.value)
               $display("%0t: value mismatch expected %h actual %h", $time, want.value,
                        got.value);
            if (got.status !== want.status)
               $display("%0t: status mismatch expected %0d actual %0d", $time, want.status,
                        got.status);
            if (got.value !== want.value || got.status !== want.status) error_count++;
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      req.valid = 1'b0;
      req.payload = '0;
      rsp.ready = 1'b0;
      clear_eval();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      wait_drained();
      test_overflow();
      test_random(400);
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

/* files.f */
rtl/ope_pkg.sv
rtl/ope_if.sv
rtl/ope_alu.sv
rtl/operator_precedence_evaluator_top.sv
dv/tb_operator_precedence_evaluator_top.sv
